// ===== design/tsd_pkg.sv =====
// Shared types and constants of the triangle shape descriptor unit.
package tsd_pkg;

    localparam int COORD_W    = 16;
    localparam int LABEL_W    = 16;
    localparam int SIDE_W     = 33;  // squared side length
    localparam int MINSQ_W    = 34;  // squared min_side
    localparam int MIN_SIDE_W = 17;
    localparam int RATIO_W    = 17;
    localparam int DIV_STEPS  = 33;  // quotient bits of num*2^32/den
    localparam int SQRT_STEPS = 17;  // root bits of a 34-bit radicand
    localparam int BACK_LAT   = 1 + DIV_STEPS + SQRT_STEPS;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 88;

    // One accepted triangle, sides already ordered.
    typedef struct packed {
        logic [LABEL_W-1:0] apex;
        logic [LABEL_W-1:0] mid;
        logic [LABEL_W-1:0] shrt;
        logic [SIDE_W-1:0]  a;
        logic [SIDE_W-1:0]  b;
        logic [SIDE_W-1:0]  c;
    } tsd_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tsd_fifo_stat_t;

endpackage

// ===== design/tsd_front.sv =====
// Front end: squared side lengths, rejection and side ordering.
module tsd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tsd_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [tsd_pkg::MIN_SIDE_W-1:0]      min_side,
    input  tsd_pkg::tsd_fifo_stat_t             stat,
    output logic                                push,
    output tsd_pkg::tsd_job_t                   job
);

    logic en;
    logic st1_valid_reg, st2_valid_reg;

    logic [15:0] la_reg, lb_reg, lc_reg;
    logic [15:0] la2_reg, lb2_reg, lc2_reg;
    logic [15:0] dxab_reg, dyab_reg, dxbc_reg, dybc_reg, dxac_reg, dyac_reg;
    logic [tsd_pkg::SIDE_W-1:0] dab_reg, dbc_reg, dac_reg;
    logic [tsd_pkg::MINSQ_W-1:0] m2_reg;

    logic [15:0] ax, ay, bx, by_coord, cx, cy;
    logic reject;

    assign ax       = s_tdata[31:16];
    assign ay       = s_tdata[47:32];
    assign bx       = s_tdata[79:64];
    assign by_coord = s_tdata[95:80];
    assign cx       = s_tdata[127:112];
    assign cy       = s_tdata[143:128];

    function automatic logic [15:0] absdiff(input logic [15:0] p, input logic [15:0] q);
        absdiff = (p > q) ? p - q : q - p;
    endfunction

    function automatic logic [tsd_pkg::SIDE_W-1:0] sqsum(input logic [15:0] p,
                                                        input logic [15:0] q);
        logic [31:0] pp, qq;
        pp = p * p;
        qq = q * q;
        sqsum = {1'b0, pp} + {1'b0, qq};
    endfunction

    assign en       = !(st2_valid_reg && stat.full);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        m2_reg <= min_side * min_side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else if (en) begin
            st1_valid_reg <= s_tvalid;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            la_reg   <= s_tdata[15:0];
            lb_reg   <= s_tdata[63:48];
            lc_reg   <= s_tdata[111:96];
            dxab_reg <= absdiff(ax, bx);
            dyab_reg <= absdiff(ay, by_coord);
            dxbc_reg <= absdiff(bx, cx);
            dybc_reg <= absdiff(by_coord, cy);
            dxac_reg <= absdiff(ax, cx);
            dyac_reg <= absdiff(ay, cy);
            la2_reg  <= la_reg;
            lb2_reg  <= lb_reg;
            lc2_reg  <= lc_reg;
            dab_reg  <= sqsum(dxab_reg, dyab_reg);
            dbc_reg  <= sqsum(dxbc_reg, dybc_reg);
            dac_reg  <= sqsum(dxac_reg, dyac_reg);
        end
    end

    assign reject = ({1'b0, dab_reg} < m2_reg) || ({1'b0, dbc_reg} < m2_reg)
                 || ({1'b0, dac_reg} < m2_reg);
    assign push   = st2_valid_reg && !stat.full && !reject;

    always_comb begin
        priority if (dab_reg >= dbc_reg && dab_reg >= dac_reg) begin
            job.a    = dab_reg;
            job.apex = lc2_reg;
            if (dbc_reg >= dac_reg) begin
                job.b = dbc_reg; job.c = dac_reg; job.mid = la2_reg; job.shrt = lb2_reg;
            end else begin
                job.b = dac_reg; job.c = dbc_reg; job.mid = lb2_reg; job.shrt = la2_reg;
            end
        end else if (dbc_reg > dab_reg && dbc_reg >= dac_reg) begin
            job.a    = dbc_reg;
            job.apex = la2_reg;
            if (dab_reg > dac_reg) begin
                job.b = dab_reg; job.c = dac_reg; job.mid = lc2_reg; job.shrt = lb2_reg;
            end else begin
                job.b = dac_reg; job.c = dab_reg; job.mid = lb2_reg; job.shrt = lc2_reg;
            end
        end else begin
            job.a    = dac_reg;
            job.apex = lb2_reg;
            if (dab_reg > dbc_reg) begin
                job.b = dab_reg; job.c = dbc_reg; job.mid = lc2_reg; job.shrt = la2_reg;
            end else begin
                job.b = dbc_reg; job.c = dab_reg; job.mid = la2_reg; job.shrt = lc2_reg;
            end
        end
    end

endmodule

// ===== design/tsd_fifo.sv =====
// Short job queue between the front end and the ratio pipeline.
module tsd_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tsd_pkg::tsd_job_t       wdata,
    input  logic                    pop,
    output tsd_pkg::tsd_job_t       rdata,
    output tsd_pkg::tsd_fifo_stat_t stat
);

    tsd_pkg::tsd_job_t mem_reg [0:tsd_pkg::FIFO_DEPTH-1];
    logic [tsd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tsd_pkg::FIFO_PTR_W:0]   count_reg;

    assign stat.full  = (count_reg == (tsd_pkg::FIFO_PTR_W+1)'(tsd_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== design/tsd_ratio.sv =====
// Pipelined floor(65536*sqrt(num/den)): long division then digit-by-digit root.
module tsd_ratio (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [tsd_pkg::SIDE_W-1:0]   num,
    input  logic [tsd_pkg::SIDE_W-1:0]   den,
    output logic [tsd_pkg::RATIO_W-1:0]  ratio
);

    localparam int ND = tsd_pkg::DIV_STEPS;
    localparam int NS = tsd_pkg::SQRT_STEPS;

    logic [32:0] drem_reg [0:ND];
    logic [32:0] dq_reg   [0:ND];
    logic [32:0] dden_reg [0:ND];
    logic        dnb_reg;
    logic        dz_reg   [0:ND+NS];

    logic [18:0] srem_reg [1:NS];
    logic [16:0] sr_reg   [1:NS];
    logic [33:0] sq_reg   [1:NS];
    logic [18:0] srem_in  [1:NS];
    logic [16:0] sr_in    [1:NS];
    logic [33:0] sq_in    [1:NS];

    // quotient of (num << 32) / den: start from num >> 1, num[0] enters first
    always_ff @(posedge aclk) begin
        if (en) begin
            drem_reg[0] <= {1'b0, num[32:1]};
            dq_reg[0]   <= '0;
            dden_reg[0] <= den;
            dnb_reg     <= num[0];
            dz_reg[0]   <= (den == '0);
        end
    end

    genvar j, i, k;
    generate
        for (j = 1; j <= ND; j++) begin : g_div
            logic [33:0] sh;
            logic        ge;
            logic        bitin;
            assign bitin = (j == 1) ? dnb_reg : 1'b0;
            assign sh    = {drem_reg[j-1], bitin};
            assign ge    = sh >= {1'b0, dden_reg[j-1]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    drem_reg[j] <= ge ? 33'(sh - {1'b0, dden_reg[j-1]}) : sh[32:0];
                    dq_reg[j]   <= {dq_reg[j-1][31:0], ge};
                    dden_reg[j] <= dden_reg[j-1];
                end
            end
        end

        for (k = 1; k <= ND + NS; k++) begin : g_dz
            always_ff @(posedge aclk) begin
                if (en) dz_reg[k] <= dz_reg[k-1];
            end
        end

        for (i = 1; i <= NS; i++) begin : g_sqrt
            logic [20:0] sh;
            logic [20:0] trial;
            logic        ge;
            if (i == 1) begin : g_first
                assign srem_in[i] = '0;
                assign sr_in[i]   = '0;
                assign sq_in[i]   = {1'b0, dq_reg[ND]};
            end else begin : g_next
                assign srem_in[i] = srem_reg[i-1];
                assign sr_in[i]   = sr_reg[i-1];
                assign sq_in[i]   = sq_reg[i-1];
            end
            assign sh    = {srem_in[i], sq_in[i][33:32]};
            assign trial = {2'b00, sr_in[i], 2'b01};
            assign ge    = sh >= trial;
            always_ff @(posedge aclk) begin
                if (en) begin
                    srem_reg[i] <= ge ? 19'(sh - trial) : sh[18:0];
                    sr_reg[i]   <= {sr_in[i][15:0], ge};
                    sq_reg[i]   <= {sq_in[i][31:0], 2'b00};
                end
            end
        end
    endgenerate

    assign ratio = dz_reg[ND+NS] ? tsd_pkg::RATIO_ONE : sr_reg[NS];

endmodule

// ===== design/tsd_back.sv =====
// Back end: pops ordered jobs and runs both side ratios through the pipeline.
module tsd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsd_pkg::tsd_job_t             job,
    input  tsd_pkg::tsd_fifo_stat_t       stat,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsd_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int LAT = tsd_pkg::BACK_LAT;

    logic en;
    logic        valid_reg [0:LAT-1];
    logic [47:0] lbl_reg   [0:LAT-1];
    logic [tsd_pkg::RATIO_W-1:0] ratio_mid, ratio_short;

    assign en  = !valid_reg[LAT-1] || m_tready;
    assign pop = en && !stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= !stat.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) lbl_reg[0] <= {job.shrt, job.mid, job.apex};
    end

    genvar k;
    generate
        for (k = 1; k < LAT; k++) begin : g_line
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) lbl_reg[k] <= lbl_reg[k-1];
            end
        end
    endgenerate

    tsd_ratio u_ratio_mid (
        .aclk  (aclk),
        .en    (en),
        .num   (job.b),
        .den   (job.a),
        .ratio (ratio_mid)
    );

    tsd_ratio u_ratio_short (
        .aclk  (aclk),
        .en    (en),
        .num   (job.c),
        .den   (job.a),
        .ratio (ratio_short)
    );

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = {6'b0, ratio_short, ratio_mid, lbl_reg[LAT-1]};

endmodule

// ===== design/triangle_shape_descriptor_unit.sv =====
// Top level of the triangle shape descriptor unit.
//
//  port group   dir  word
//  s_*          in   one triangle: three labels and Q12.4 points
//  m_*          out  labels opposite longest/middle/shortest, two Q1.16 ratios
//  APB          in   min_side at byte address 0
//
// One triangle per cycle sustained while m_tready stays high. The ratio pipeline
// runs 33 division steps, then 17 root steps. Rejected triangles leave nothing
// behind. aresetn is synchronous, active low. Output stalls freeze the ratio
// pipeline; the 4-word queue then absorbs the front end until it fills, and
// s_tready drops.
module triangle_shape_descriptor_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // label_a, ax, ay, label_b, bx, by_coord, label_c, cx, cy (16 bits each)
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // apex_label(16), mid_label(16), short_label(16), ratio_mid(17), ratio_short(17)
    output logic [87:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [tsd_pkg::MIN_SIDE_W-1:0] min_side_reg;
    logic push, pop;
    tsd_pkg::tsd_job_t       wjob, rjob;
    tsd_pkg::tsd_fifo_stat_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {15'b0, min_side_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_side_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            min_side_reg <= pwdata[16:0];
        end
    end

    tsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .min_side (min_side_reg),
        .stat     (stat),
        .push     (push),
        .job      (wjob)
    );

    tsd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (wjob),
        .pop     (pop),
        .rdata   (rjob),
        .stat    (stat)
    );

    tsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job      (rjob),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full) else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty) else $error("queue read while empty");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> stat.full) else $error("input stalled with room in queue");

    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!m_tvalid || m_tready)) else $error("pop while pipeline held");

endmodule
